// File: hw/rtl/vnt_pkg.sv
// ----------------------------------------------------------------------------
// Vertex/normal transform package
// Shared widths, types and the derivation sequencer states.
// ----------------------------------------------------------------------------
package vnt_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COEF_W     = 32;
    localparam int NUM_REGS   = 8;
    localparam int CFG_SEL_W  = $clog2(NUM_REGS);
    localparam int CFG_IDX_W  = CFG_SEL_W + 1;
    localparam int CFG_DATA_W = 2 * COEF_W;
    localparam int MAT_N      = 4;
    localparam int NM_N       = 9;

    typedef logic signed [COEF_W-1:0] t_coef;

    typedef struct packed {
        logic busy;
        logic singular;
    } t_drv_status;

    typedef enum logic [3:0] {
        DRV_IDLE,
        DRV_INIT,
        DRV_MUL,
        DRV_ADD,
        DRV_RND,
        DRV_ACC,
        DRV_MAX,
        DRV_SHIFT,
        DRV_WRITE
    } t_drv_state;

endpackage

// File: hw/rtl/vnt_req_if.sv
// ----------------------------------------------------------------------------
// Vertex/normal transform request channel
// Valid/ready channel carrying the mode and the three input components.
// ----------------------------------------------------------------------------
interface vnt_req_if import vnt_pkg::*;;
    logic  valid;
    logic  ready;
    logic  mode;
    t_coef in_x;
    t_coef in_y;
    t_coef in_z;

    modport source (output valid, mode, in_x, in_y, in_z, input ready);
    modport sink   (input valid, mode, in_x, in_y, in_z, output ready);
endinterface

// File: hw/rtl/vnt_rsp_if.sv
// ----------------------------------------------------------------------------
// Vertex/normal transform response channel
// Valid/ready channel carrying the transformed vector and the degenerate flag.
// ----------------------------------------------------------------------------
interface vnt_rsp_if import vnt_pkg::*;;
    logic  valid;
    logic  ready;
    t_coef out_x;
    t_coef out_y;
    t_coef out_z;
    logic  degenerate;

    modport source (output valid, out_x, out_y, out_z, degenerate, input ready);
    modport sink   (input valid, out_x, out_y, out_z, degenerate, output ready);
endinterface

// File: hw/rtl/vnt_derive.sv
// ----------------------------------------------------------------------------
// Normal matrix derivation
// Sequencer around one 32x32 multiplier that forms the cofactors of the
// matrix, its determinant and the scaled 3x3 normal matrix.
// ----------------------------------------------------------------------------
module vnt_derive import vnt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_coef       i_mat [MAT_N][MAT_N],
    output t_coef       o_nm [NM_N],
    output t_drv_status o_status
);

    localparam int W      = 64;
    localparam int H      = W / 2;
    localparam int NCOF   = 12;
    localparam int NUM_T  = 4;
    localparam int K_W    = 6;
    localparam int NM_LIM = 30;
    localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W:0] SAT_HI = {2'b00, {(W-1){1'b1}}};
    localparam logic signed [W:0] SAT_LO = -SAT_HI;

    t_drv_state r_state, n_state;

    logic [3:0]          r_c;
    logic [3:0]          r_s;
    logic                r_detph;
    logic [1:0]          r_mph;
    logic [2*W-1:0]      r_acc;
    logic [W-1:0]        r_pp;
    logic signed [W-1:0] r_prod;
    logic signed [W-1:0] r_det;
    logic signed [W-1:0] r_t [NUM_T];
    logic signed [W-1:0] r_cof [NCOF];
    logic [W-1:0]        r_mx;
    logic [K_W-1:0]      r_k;
    logic [3:0]          r_e;
    t_coef               r_nm [NM_N];
    logic                r_sing;

    t_coef               sub [NM_N];
    logic [1:0]          ci, cj;
    logic [3:0]          ka, kb;
    logic                b_reg, set_f, sub_f;
    logic [1:0]          b_t, dst;
    logic signed [W-1:0] op_a, op_b;
    logic [W-1:0]        mag_a, mag_b;
    logic                neg;
    logic [H-1:0]        ah, bh;
    logic [1:0]          sh;
    logic [2*W-1:0]      rnd;
    logic                ovf;
    logic [W-1:0]        mg;
    logic signed [W-1:0] base, addend;
    logic signed [W:0]   sum;
    logic signed [W-1:0] satv;
    logic [3:0]          cof_rd_idx;
    logic signed [W-1:0] cof_rd, vneg, v;
    logic [W-1:0]        vmag, vsh;
    logic                last_cof, last_step;

    assign ci = r_c[3:2];
    assign cj = r_c[1:0];

    // Entries of the 3x3 minor that drops row ci and column cj.
    always_comb begin
        logic [1:0] rr, cc, row, col;
        for (int k = 0; k < NM_N; k++) begin
            rr  = 2'(k / 3);
            cc  = 2'(k % 3);
            row = rr + ((rr >= ci) ? 2'd1 : 2'd0);
            col = cc + ((cc >= cj) ? 2'd1 : 2'd0);
            sub[k] = i_mat[row][col];
        end
    end

    // Operand schedule for one 3x3 determinant, expanded along its top row.
    always_comb begin
        ka = 4'd4; kb = 4'd8; b_reg = 1'b0; b_t = 2'd0; dst = 2'd0;
        set_f = 1'b1; sub_f = 1'b0;
        case (r_s)
            4'd0: begin ka = 4'd4; kb = 4'd8; dst = 2'd0; end
            4'd1: begin ka = 4'd5; kb = 4'd7; dst = 2'd0; set_f = 1'b0; sub_f = 1'b1; end
            4'd2: begin ka = 4'd3; kb = 4'd8; dst = 2'd1; end
            4'd3: begin ka = 4'd5; kb = 4'd6; dst = 2'd1; set_f = 1'b0; sub_f = 1'b1; end
            4'd4: begin ka = 4'd3; kb = 4'd7; dst = 2'd2; end
            4'd5: begin ka = 4'd4; kb = 4'd6; dst = 2'd2; set_f = 1'b0; sub_f = 1'b1; end
            4'd6: begin ka = 4'd0; b_reg = 1'b1; b_t = 2'd0; dst = 2'd3; end
            4'd7: begin
                ka = 4'd1; b_reg = 1'b1; b_t = 2'd1; dst = 2'd3;
                set_f = 1'b0; sub_f = 1'b1;
            end
            4'd8: begin ka = 4'd2; b_reg = 1'b1; b_t = 2'd2; dst = 2'd3; set_f = 1'b0; end
            default: begin ka = 4'd4; kb = 4'd8; end
        endcase
        if (r_detph) begin
            set_f = 1'b0;
            sub_f = 1'b0;
        end
    end

    // One read port into the cofactor file, shared by the determinant and
    // the normal matrix passes.
    always_comb begin
        if (r_detph && r_state != DRV_MAX && r_state != DRV_WRITE) begin
            cof_rd_idx = {2'b00, r_s[1:0]};
        end else begin
            case (r_e)
                4'd0: cof_rd_idx = 4'd0;
                4'd1: cof_rd_idx = 4'd1;
                4'd2: cof_rd_idx = 4'd2;
                4'd3: cof_rd_idx = 4'd4;
                4'd4: cof_rd_idx = 4'd5;
                4'd5: cof_rd_idx = 4'd6;
                4'd6: cof_rd_idx = 4'd8;
                4'd7: cof_rd_idx = 4'd9;
                4'd8: cof_rd_idx = 4'd10;
                default: cof_rd_idx = 4'd0;
            endcase
        end
        cof_rd = r_cof[cof_rd_idx];
    end

    always_comb begin
        if (r_detph) begin
            op_a = W'(i_mat[0][r_s[1:0]]);
            op_b = cof_rd;
        end else begin
            op_a = W'(sub[ka]);
            op_b = b_reg ? r_t[b_t] : W'(sub[kb]);
        end
        neg   = op_a[W-1] ^ op_b[W-1];
        mag_a = op_a[W-1] ? W'(-op_a) : W'(op_a);
        mag_b = op_b[W-1] ? W'(-op_b) : W'(op_b);
        ah    = r_mph[0] ? mag_a[W-1:H] : mag_a[H-1:0];
        bh    = r_mph[1] ? mag_b[W-1:H] : mag_b[H-1:0];
        sh    = {1'b0, r_mph[0]} + {1'b0, r_mph[1]};

        // Round half away from zero on the magnitude, then saturate.
        rnd = r_acc + ((2*W)'(1) << (FRAC_BITS - 1));
        ovf = (|rnd[2*W-1:W+FRAC_BITS]) | rnd[W-1+FRAC_BITS];
        mg  = ovf ? SMAX : {1'b0, rnd[W-2+FRAC_BITS:FRAC_BITS]};

        if (set_f) begin
            base = '0;
        end else if (r_detph) begin
            base = r_det;
        end else begin
            base = r_t[dst];
        end
        addend = sub_f ? -r_prod : r_prod;
        sum    = {base[W-1], base} + {addend[W-1], addend};
        if (sum > SAT_HI) begin
            satv = SAT_HI[W-1:0];
        end else if (sum < SAT_LO) begin
            satv = SAT_LO[W-1:0];
        end else begin
            satv = sum[W-1:0];
        end

        vneg = r_det[W-1] ? -cof_rd : cof_rd;
        v    = (r_det == '0) ? '0 : vneg;
        vmag = v[W-1] ? W'(-v) : W'(v);
        vsh  = vmag >> r_k;

        last_cof  = (r_s == 4'd8);
        last_step = r_detph ? (r_s == 4'd3) : (last_cof && r_c == 4'(NCOF - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DRV_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            DRV_IDLE:  n_state = DRV_IDLE;
            DRV_INIT:  n_state = DRV_MUL;
            DRV_MUL:   n_state = DRV_ADD;
            DRV_ADD:   n_state = (r_mph == 2'd3) ? DRV_RND : DRV_MUL;
            DRV_RND:   n_state = DRV_ACC;
            DRV_ACC:   n_state = (r_detph && last_step) ? DRV_MAX : DRV_MUL;
            DRV_MAX:   n_state = (r_e == 4'(NM_N - 1)) ? DRV_SHIFT : DRV_MAX;
            DRV_SHIFT: n_state = (r_mx < (W'(1) << NM_LIM)) ? DRV_WRITE : DRV_SHIFT;
            DRV_WRITE: n_state = (r_e == 4'(NM_N - 1)) ? DRV_IDLE : DRV_WRITE;
            default:   n_state = DRV_INIT;
        endcase
        if (i_start) begin
            n_state = DRV_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            DRV_INIT: begin
                r_c     <= '0;
                r_s     <= '0;
                r_detph <= 1'b0;
                r_mph   <= '0;
                r_acc   <= '0;
                r_det   <= '0;
                r_mx    <= '0;
                r_k     <= '0;
                r_e     <= '0;
            end
            DRV_MUL: r_pp <= ah * bh;
            DRV_ADD: begin
                r_acc <= r_acc + ({{W{1'b0}}, r_pp} << {sh, 5'b0});
                r_mph <= r_mph + 2'd1;
            end
            DRV_RND: r_prod <= neg ? -$signed(mg) : $signed(mg);
            DRV_ACC: begin
                r_acc <= '0;
                r_mph <= '0;
                if (r_detph) begin
                    r_det <= satv;
                    r_s   <= r_s + 4'd1;
                    r_e   <= '0;
                    r_mx  <= '0;
                end else if (last_cof) begin
                    // Odd row plus column takes the negated minor.
                    r_cof[r_c] <= (r_c[2] ^ r_c[0]) ? -satv : satv;
                    r_s        <= '0;
                    if (r_c == 4'(NCOF - 1)) begin
                        r_detph <= 1'b1;
                    end else begin
                        r_c <= r_c + 4'd1;
                    end
                end else begin
                    r_t[dst] <= satv;
                    r_s      <= r_s + 4'd1;
                end
            end
            DRV_MAX: begin
                if (vmag > r_mx) begin
                    r_mx <= vmag;
                end
                r_e <= (r_e == 4'(NM_N - 1)) ? 4'd0 : r_e + 4'd1;
            end
            DRV_SHIFT: begin
                if (r_mx >= (W'(1) << NM_LIM)) begin
                    r_mx <= r_mx >> 1;
                    r_k  <= r_k + K_W'(1);
                end
            end
            DRV_WRITE: begin
                r_nm[r_e] <= v[W-1] ? -t_coef'(vsh[COEF_W-1:0]) : t_coef'(vsh[COEF_W-1:0]);
                r_sing    <= (r_det == '0);
                r_e       <= r_e + 4'd1;
            end
            default: r_pp <= r_pp;
        endcase
    end

    assign o_nm              = r_nm;
    assign o_status.busy     = (r_state != DRV_IDLE);
    assign o_status.singular = r_sing;

endmodule

// File: hw/rtl/vnt_datapath.sv
// ----------------------------------------------------------------------------
// Vertex/normal transform datapath
// Fully pipelined: multiply, sum, normalize, square, bit-per-stage square
// root and bit-per-stage division, all advancing on one enable.
// ----------------------------------------------------------------------------
module vnt_datapath import vnt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  logic  i_mode,
    input  t_coef i_x,
    input  t_coef i_y,
    input  t_coef i_z,
    input  t_coef i_mat [MAT_N][MAT_N],
    input  t_coef i_nm [NM_N],
    input  logic  i_singular,
    output logic  o_valid,
    output t_coef o_x,
    output t_coef o_y,
    output t_coef o_z,
    output logic  o_deg
);

    localparam int P_W    = 2 * COEF_W;
    localparam int S_W    = P_W + 3;
    localparam int U_W    = P_W;
    localparam int LD_W   = $clog2(U_W);
    localparam int NU_W   = 30;
    localparam int SQ_W   = 2 * NU_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int ISQ_N  = 32;
    localparam int R_W    = 2 * ISQ_N - 1;
    localparam int L_W    = ISQ_N - 1;
    localparam int Q_BITS = FRAC_BITS + 1;
    localparam int N_W    = NU_W + FRAC_BITS + 2;
    localparam logic signed [S_W-1:0] C_MAX = S_W'(32'sh7FFF_FFFF);
    localparam logic signed [S_W-1:0] C_MIN = S_W'(32'sh8000_0000);

    typedef struct packed {
        logic        mode;
        logic        deg;
        logic [2:0]  sg;
        t_coef [2:0] vo;
    } t_tag;

    // Stage 0: accepted request.
    logic              r0_v, r0_mode;
    t_coef             r0_n [3];
    // Stage 1: products.
    logic              r1_v, r1_mode;
    logic signed [P_W-1:0] r1_p [3][3];
    // Stage 2: row sums.
    logic              r2_v, r2_mode;
    logic signed [S_W-1:0] r2_s [3];
    // Stage 3: vertex result and normal magnitudes.
    logic              r3_v;
    t_tag              r3_t;
    logic [U_W-1:0]    r3_u [3];
    // Stage 4: largest magnitude.
    logic              r4_v;
    t_tag              r4_t;
    logic [U_W-1:0]    r4_u [3];
    logic [U_W-1:0]    r4_mx;
    // Stage 5: leading one position.
    logic              r5_v;
    t_tag              r5_t;
    logic [U_W-1:0]    r5_u [3];
    logic [LD_W-1:0]   r5_ld;
    // Stage 6: normalized magnitudes.
    logic              r6_v;
    t_tag              r6_t;
    logic [NU_W-1:0]   r6_u [3];
    // Stage 7: squares.
    logic              r7_v;
    t_tag              r7_t;
    logic [NU_W-1:0]   r7_u [3];
    logic [SQ_W-1:0]   r7_sq [3];
    // Stage 8: sum of squares.
    logic              r8_v;
    t_tag              r8_t;
    logic [NU_W-1:0]   r8_u [3];
    logic [SUM_W-1:0]  r8_sum;
    // Square root stages.
    logic              rq_v [ISQ_N];
    t_tag              rq_t [ISQ_N];
    logic [NU_W-1:0]   rq_u [ISQ_N][3];
    logic [R_W-1:0]    rq_s [ISQ_N];
    logic [R_W-1:0]    rq_r [ISQ_N];
    // Dividend preparation.
    logic              rp_v;
    t_tag              rp_t;
    logic [L_W-1:0]    rp_l;
    logic [N_W-1:0]    rp_n [3];
    // Division stages.
    logic              rd_v [Q_BITS];
    t_tag              rd_t [Q_BITS];
    logic [L_W-1:0]    rd_l [Q_BITS];
    logic [N_W-1:0]    rd_n [Q_BITS][3];
    logic [Q_BITS-1:0] rd_q [Q_BITS][3];

    t_coef             in_n [3];
    t_coef             coef [3][3];
    logic signed [S_W-1:0] vw [3], vsh [3], vab [3];
    t_coef             vclp [3];
    logic [U_W-1:0]    mx01, mx;
    logic [LD_W-1:0]   ld;
    logic [NU_W-1:0]   nu [3];
    logic [R_W-1:0]    qs_in [ISQ_N], qr_in [ISQ_N], qs_out [ISQ_N], qr_out [ISQ_N];
    logic [R_W-1:0]    qtst [ISQ_N];
    logic [N_W-1:0]    dn_in [Q_BITS][3], dn_out [Q_BITS][3], dv [Q_BITS];
    logic [Q_BITS-1:0] dq_in [Q_BITS][3], dq_out [Q_BITS][3];
    t_tag              dt_in [Q_BITS];
    logic [L_W-1:0]    dl_in [Q_BITS];
    logic              dvl_in [Q_BITS];

    assign in_n[0] = r0_n[0];
    assign in_n[1] = r0_n[1];
    assign in_n[2] = r0_n[2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                coef[i][j] = r0_mode ? i_nm[i*3 + j] : i_mat[i][j];
            end
        end
        for (int i = 0; i < 3; i++) begin
            vw[i]  = r2_s[i] + (S_W'(i_mat[i][3]) <<< FRAC_BITS)
                   + (S_W'(1) <<< (FRAC_BITS - 1));
            vsh[i] = vw[i] >>> FRAC_BITS;
            if (vsh[i] > C_MAX) begin
                vclp[i] = C_MAX[COEF_W-1:0];
            end else if (vsh[i] < C_MIN) begin
                vclp[i] = C_MIN[COEF_W-1:0];
            end else begin
                vclp[i] = vsh[i][COEF_W-1:0];
            end
            vab[i] = r2_s[i][S_W-1] ? -r2_s[i] : r2_s[i];
        end
        mx01 = (r3_u[0] > r3_u[1]) ? r3_u[0] : r3_u[1];
        mx   = (mx01 > r3_u[2]) ? mx01 : r3_u[2];
        ld = '0;
        for (int b = 0; b < U_W; b++) begin
            if (r4_mx[b]) begin
                ld = LD_W'(b);
            end
        end
        // Bring the largest magnitude into [2^29, 2^30).
        for (int i = 0; i < 3; i++) begin
            if (r5_ld >= LD_W'(NU_W)) begin
                nu[i] = NU_W'(r5_u[i] >> (r5_ld - LD_W'(NU_W - 1)));
            end else begin
                nu[i] = NU_W'(r5_u[i] << (LD_W'(NU_W - 1) - r5_ld));
            end
        end
    end

    // Square root, one result bit per stage.
    always_comb begin
        for (int k = 0; k < ISQ_N; k++) begin
            if (k == 0) begin
                qs_in[k] = R_W'(r8_sum);
                qr_in[k] = '0;
            end else begin
                qs_in[k] = rq_s[k-1];
                qr_in[k] = rq_r[k-1];
            end
            qtst[k] = qr_in[k] + (R_W'(1) << (R_W - 1 - 2*k));
            if (qs_in[k] >= qtst[k]) begin
                qs_out[k] = qs_in[k] - qtst[k];
                qr_out[k] = (qr_in[k] >> 1) + (R_W'(1) << (R_W - 1 - 2*k));
            end else begin
                qs_out[k] = qs_in[k];
                qr_out[k] = qr_in[k] >> 1;
            end
        end
    end

    // Restoring division, one quotient bit per stage from the top.
    always_comb begin
        for (int d = 0; d < Q_BITS; d++) begin
            if (d == 0) begin
                dvl_in[d] = rp_v;
                dt_in[d]  = rp_t;
                dl_in[d]  = rp_l;
                for (int i = 0; i < 3; i++) begin
                    dn_in[d][i] = rp_n[i];
                    dq_in[d][i] = '0;
                end
            end else begin
                dvl_in[d] = rd_v[d-1];
                dt_in[d]  = rd_t[d-1];
                dl_in[d]  = rd_l[d-1];
                for (int i = 0; i < 3; i++) begin
                    dn_in[d][i] = rd_n[d-1][i];
                    dq_in[d][i] = rd_q[d-1][i];
                end
            end
            dv[d] = N_W'(dl_in[d]) << (Q_BITS - 1 - d);
            for (int i = 0; i < 3; i++) begin
                if (dn_in[d][i] >= dv[d]) begin
                    dn_out[d][i] = dn_in[d][i] - dv[d];
                    dq_out[d][i] = dq_in[d][i] | (Q_BITS'(1) << (Q_BITS - 1 - d));
                end else begin
                    dn_out[d][i] = dn_in[d][i];
                    dq_out[d][i] = dq_in[d][i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            rp_v <= 1'b0;
            for (int k = 0; k < ISQ_N; k++) begin
                rq_v[k] <= 1'b0;
            end
            for (int d = 0; d < Q_BITS; d++) begin
                rd_v[d] <= 1'b0;
            end
        end else if (i_en) begin
            r0_v <= i_valid;
            r1_v <= r0_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= r7_v;
            for (int k = 0; k < ISQ_N; k++) begin
                rq_v[k] <= (k == 0) ? r8_v : rq_v[k-1];
            end
            rp_v <= rq_v[ISQ_N-1];
            for (int d = 0; d < Q_BITS; d++) begin
                rd_v[d] <= dvl_in[d];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_mode <= i_mode;
            r0_n[0] <= i_x;
            r0_n[1] <= i_y;
            r0_n[2] <= i_z;

            r1_mode <= r0_mode;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r1_p[i][j] <= coef[i][j] * in_n[j];
                end
            end

            r2_mode <= r1_mode;
            for (int i = 0; i < 3; i++) begin
                r2_s[i] <= S_W'(r1_p[i][0]) + S_W'(r1_p[i][1]) + S_W'(r1_p[i][2]);
            end

            r3_t.mode <= r2_mode;
            r3_t.deg  <= r2_mode && (i_singular ||
                         (r2_s[0] == '0 && r2_s[1] == '0 && r2_s[2] == '0));
            for (int i = 0; i < 3; i++) begin
                r3_t.sg[i] <= r2_s[i][S_W-1];
                r3_t.vo[i] <= vclp[i];
                r3_u[i]    <= vab[i][U_W-1:0];
            end

            r4_t  <= r3_t;
            r4_u  <= r3_u;
            r4_mx <= mx;

            r5_t  <= r4_t;
            r5_u  <= r4_u;
            r5_ld <= ld;

            r6_t <= r5_t;
            r6_u <= nu;

            r7_t <= r6_t;
            r7_u <= r6_u;
            for (int i = 0; i < 3; i++) begin
                r7_sq[i] <= r6_u[i] * r6_u[i];
            end

            r8_t   <= r7_t;
            r8_u   <= r7_u;
            r8_sum <= SUM_W'(r7_sq[0]) + SUM_W'(r7_sq[1]) + SUM_W'(r7_sq[2]);

            for (int k = 0; k < ISQ_N; k++) begin
                rq_s[k] <= qs_out[k];
                rq_r[k] <= qr_out[k];
                if (k == 0) begin
                    rq_t[k] <= r8_t;
                    rq_u[k] <= r8_u;
                end else begin
                    rq_t[k] <= rq_t[k-1];
                    rq_u[k] <= rq_u[k-1];
                end
            end

            rp_t <= rq_t[ISQ_N-1];
            rp_l <= rq_r[ISQ_N-1][L_W-1:0];
            for (int i = 0; i < 3; i++) begin
                rp_n[i] <= (N_W'(rq_u[ISQ_N-1][i]) << FRAC_BITS)
                         + N_W'(rq_r[ISQ_N-1][L_W-1:1]);
            end

            for (int d = 0; d < Q_BITS; d++) begin
                rd_t[d] <= dt_in[d];
                rd_l[d] <= dl_in[d];
                rd_n[d] <= dn_out[d];
                rd_q[d] <= dq_out[d];
            end
        end
    end

    always_comb begin
        t_tag  ft;
        t_coef nq [3];
        ft = rd_t[Q_BITS-1];
        for (int i = 0; i < 3; i++) begin
            nq[i] = ft.sg[i] ? -COEF_W'(rd_q[Q_BITS-1][i]) : COEF_W'(rd_q[Q_BITS-1][i]);
        end
        o_valid = rd_v[Q_BITS-1];
        if (!ft.mode) begin
            o_x = ft.vo[0];
            o_y = ft.vo[1];
            o_z = ft.vo[2];
            o_deg = 1'b0;
        end else if (ft.deg) begin
            o_x = '0;
            o_y = '0;
            o_z = '0;
            o_deg = 1'b1;
        end else begin
            o_x = nq[0];
            o_y = nq[1];
            o_z = nq[2];
            o_deg = 1'b0;
        end
    end

endmodule

// File: hw/rtl/vertex_normal_transform.sv
// ----------------------------------------------------------------------------
// Vertex and normal transform by a 4x4 fixed-point matrix
//
//   channel   direction  contents
//   i_req     in         mode, in_x, in_y, in_z (signed Q16.16)
//   o_rsp     out        out_x, out_y, out_z (signed Q16.16), degenerate
//   i_cfg_*   in         write enable, register index, 64-bit data
//
// One request per cycle when the sequencer is idle and no skid entry waits.
// The result reaches the output register through 9 arithmetic stages, 32
// square root stages, one dividend stage and 17 division stages.
// After reset and after each register write the derivation sequencer runs
// with one shared 32x32 multiplier (112 products, then the scaling passes);
// requests are held off while it runs.
// Reset is synchronous and restarts that derivation.
// A stalled output parks one result in a skid register; the pipeline then
// holds as a whole until the skid register drains.
// ----------------------------------------------------------------------------
module vertex_normal_transform import vnt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    vnt_req_if.sink               i_req,
    vnt_rsp_if.source             o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef struct packed {
        t_coef x;
        t_coef y;
        t_coef z;
        logic  deg;
    } t_rsp;

    logic [CFG_DATA_W-1:0] r_cfg [NUM_REGS];
    t_coef                 mat [MAT_N][MAT_N];
    t_coef                 nm [NM_N];
    t_drv_status           st;
    logic                  cfg_hit;
    logic                  en, push, out_free;
    logic                  p_valid, p_deg;
    t_coef                 p_x, p_y, p_z;
    t_rsp                  p_data;
    logic                  r_ov, r_sv;
    t_rsp                  r_od, r_sd;

    assign cfg_hit = i_cfg_we && (i_cfg_idx < CFG_IDX_W'(NUM_REGS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= '0;
            end
            r_cfg[0] <= CFG_DATA_W'(1) << FRAC_BITS;
            r_cfg[2] <= CFG_DATA_W'(1) << (COEF_W + FRAC_BITS);
            r_cfg[5] <= CFG_DATA_W'(1) << FRAC_BITS;
            r_cfg[7] <= CFG_DATA_W'(1) << (COEF_W + FRAC_BITS);
        end else if (cfg_hit) begin
            r_cfg[i_cfg_idx[CFG_SEL_W-1:0]] <= i_cfg_data;
        end
    end

    always_comb begin
        for (int i = 0; i < MAT_N; i++) begin
            mat[i][0] = r_cfg[2*i][COEF_W-1:0];
            mat[i][1] = r_cfg[2*i][2*COEF_W-1:COEF_W];
            mat[i][2] = r_cfg[2*i+1][COEF_W-1:0];
            mat[i][3] = r_cfg[2*i+1][2*COEF_W-1:COEF_W];
        end
    end

    vnt_derive u_derive (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (cfg_hit),
        .i_mat    (mat),
        .o_nm     (nm),
        .o_status (st)
    );

    assign en          = !r_sv;
    assign i_req.ready = en && !st.busy;

    vnt_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_req.valid && i_req.ready),
        .i_mode     (i_req.mode),
        .i_x        (i_req.in_x),
        .i_y        (i_req.in_y),
        .i_z        (i_req.in_z),
        .i_mat      (mat),
        .i_nm       (nm),
        .i_singular (st.singular),
        .o_valid    (p_valid),
        .o_x        (p_x),
        .o_y        (p_y),
        .o_z        (p_z),
        .o_deg      (p_deg)
    );

    assign p_data   = '{x: p_x, y: p_y, z: p_z, deg: p_deg};
    assign push     = en && p_valid;
    assign out_free = !r_ov || o_rsp.ready;

    // Output register with a one-entry skid behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (out_free) begin
            r_ov <= r_sv || push;
            r_sv <= 1'b0;
        end else if (push) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_od <= r_sv ? r_sd : p_data;
        end else if (push) begin
            r_sd <= p_data;
        end
    end

    assign o_rsp.valid      = r_ov;
    assign o_rsp.out_x      = r_od.x;
    assign o_rsp.out_y      = r_od.y;
    assign o_rsp.out_z      = r_od.z;
    assign o_rsp.degenerate = r_od.deg;

endmodule

// File: tb/tb_vertex_normal_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex/normal transform testbench
// Drives position and normal requests through a series of matrix settings,
// predicts unlisted results with an in-bench fixed-point transform copy and
// checks responses in order; both channels idle at random for the first 400.
// ----------------------------------------------------------------------------
module tb_vertex_normal_transform;
    import vnt_pkg::*;

    localparam longint SMAX       = 64'sh7fff_ffff_ffff_ffff;
    localparam int     MAX_CYCLES = 400000;
    localparam int     DRAIN_WAIT = 80;
    localparam int     PHASES     = 10;
    localparam int     PHASE_LEN  = 58;

    typedef enum logic {MODE_VERTEX = 1'b0, MODE_NORMAL = 1'b1} t_mode;

    typedef enum int {
        MAT_SMALL, MAT_ZERO, MAT_ALL_MAX, MAT_ALL_MIN, MAT_RAW_BITS, MAT_SMALL_BAD_IDX
    } t_mat_style;

    typedef struct packed {
        t_coef x;
        t_coef y;
        t_coef z;
        logic  degenerate;
    } t_vec_result;

    typedef struct {
        t_mode       mode;
        t_coef       x;
        t_coef       y;
        t_coef       z;
        bit          known;
        t_vec_result res;
    } t_directed_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    vnt_req_if req_ch ();
    vnt_rsp_if rsp_ch ();

    vertex_normal_transform dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow of the matrix registers and the derived normal matrix.
    logic [63:0] mat_regs [NUM_REGS];
    longint      mat [4][4];
    longint      nrm_mat [NM_N];
    bit          nrm_singular;

    t_vec_result pending_vectors [$];
    int          error_count  = 0;
    int          cycle_count  = 0;
    int          sent_count   = 0;
    int          send_idle_pct;
    int          recv_idle_pct;

    function automatic longint fx_mul(longint a, longint b);
        logic [63:0]  ua, ub;
        logic [127:0] p;
        bit           neg;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        p   = {64'd0, ua} * {64'd0, ub};
        p   = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (p > 128'(SMAX)) p = 128'(SMAX);
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint fx_add(longint a, longint b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > SMAX) return SMAX;
        if (s < -SMAX) return -SMAX;
        return longint'(s);
    endfunction

    function automatic longint det3x3(longint a [9]);
        longint t0, t1, t2, s;
        t0 = fx_add(fx_mul(a[4], a[8]), -fx_mul(a[5], a[7]));
        t1 = fx_add(fx_mul(a[3], a[8]), -fx_mul(a[5], a[6]));
        t2 = fx_add(fx_mul(a[3], a[7]), -fx_mul(a[4], a[6]));
        s  = fx_add(fx_mul(a[0], t0), -fx_mul(a[1], t1));
        return fx_add(s, fx_mul(a[2], t2));
    endfunction

    function automatic longint cofactor_of(int i, int j);
        longint sub [9];
        longint d;
        int     k;
        k = 0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (r != i && c != j) begin
                    sub[k] = mat[r][c];
                    k++;
                end
            end
        end
        d = det3x3(sub);
        return ((i + j) % 2 == 1) ? -d : d;
    endfunction

    // Normal matrix: upper 3x3 cofactors times the sign of the determinant,
    // then one common shift so every magnitude fits below 2^30.
    function automatic void rebuild_normal_matrix();
        longint      cof [3][4];
        longint      det, v;
        logic [63:0] mx, m;
        int          k;
        det = 0;
        mx  = 0;
        k   = 0;
        for (int i = 0; i < 4; i++) begin
            mat[i][0] = t_coef'(mat_regs[2*i][31:0]);
            mat[i][1] = t_coef'(mat_regs[2*i][63:32]);
            mat[i][2] = t_coef'(mat_regs[2*i+1][31:0]);
            mat[i][3] = t_coef'(mat_regs[2*i+1][63:32]);
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 4; j++)
                cof[i][j] = cofactor_of(i, j);
        for (int j = 0; j < 4; j++)
            det = fx_add(det, fx_mul(mat[0][j], cof[0][j]));
        nrm_singular = (det == 0);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                v = (det < 0) ? -cof[i][j] : cof[i][j];
                if (nrm_singular) v = 0;
                nrm_mat[i*3+j] = v;
                m = (v < 0) ? -v : v;
                if (m > mx) mx = m;
            end
        end
        while ((mx >> k) >= (64'd1 << 30)) k++;
        for (int i = 0; i < NM_N; i++) begin
            v = nrm_mat[i];
            m = ((v < 0) ? -v : v) >> k;
            nrm_mat[i] = (v < 0) ? -longint'(m) : longint'(m);
        end
    endfunction

    function automatic t_coef clamp_coef(logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'sh7fff_ffff;
        if (v < -128'sd2147483648) return 32'sh8000_0000;
        return t_coef'(v[31:0]);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] s);
        logic [63:0] res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s   = s - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic t_vec_result transform_vector(t_mode mode, t_coef x, t_coef y, t_coef z);
        t_vec_result        r;
        longint             n [4];
        logic signed [127:0] acc;
        logic signed [127:0] v [3];
        logic [63:0]        u [3];
        logic [63:0]        mx, sum, len, o;
        t_coef              outs [3];
        n[0] = x;
        n[1] = y;
        n[2] = z;
        n[3] = longint'(1) << FRAC_BITS;
        r = '0;
        if (mode == MODE_VERTEX) begin
            for (int i = 0; i < 3; i++) begin
                acc = 0;
                for (int j = 0; j < 4; j++) acc = acc + mat[i][j] * n[j];
                acc = (acc + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
                outs[i] = clamp_coef(acc);
            end
            r.x = outs[0];
            r.y = outs[1];
            r.z = outs[2];
            return r;
        end
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            v[i] = 0;
            for (int j = 0; j < 3; j++) v[i] = v[i] + nrm_mat[i*3+j] * n[j];
            u[i] = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
            if (u[i] > mx) mx = u[i];
        end
        if (nrm_singular || mx == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        while (mx >= (64'd1 << 30)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) u[i] >>= 1;
        end
        while (mx < (64'd1 << 29)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) u[i] <<= 1;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) sum += u[i] * u[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            o = ((u[i] << FRAC_BITS) + (len >> 1)) / len;
            outs[i] = clamp_coef((v[i] < 0) ? -$signed({64'd0, o}) : $signed({64'd0, o}));
        end
        r.x = outs[0];
        r.y = outs[1];
        r.z = outs[2];
        return r;
    endfunction

    // Response checker: samples mid-cycle, so the handshake seen here is the
    // one that completes at the next rising edge.
    always @(negedge i_clk) begin
        t_vec_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_vectors.size() == 0) begin
                $error("Response with no request outstanding");
                error_count++;
            end else begin
                want = pending_vectors.pop_front();
                if (rsp_ch.out_x !== want.x) begin
                    $error("out_x expected %0d actual %0d", want.x, rsp_ch.out_x);
                    error_count++;
                end
                if (rsp_ch.out_y !== want.y) begin
                    $error("out_y expected %0d actual %0d", want.y, rsp_ch.out_y);
                    error_count++;
                end
                if (rsp_ch.out_z !== want.z) begin
                    $error("out_z expected %0d actual %0d", want.z, rsp_ch.out_z);
                    error_count++;
                end
                if (rsp_ch.degenerate !== want.degenerate) begin
                    $error("degenerate expected %0b actual %0b",
                           want.degenerate, rsp_ch.degenerate);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        rsp_ch.ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == MAX_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void update_idle_profile();
        if (sent_count < 200) begin
            send_idle_pct = 18;
            recv_idle_pct = 83;
        end else if (sent_count < 400) begin
            send_idle_pct = 83;
            recv_idle_pct = 18;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endfunction

    // Called just after a rising edge; returns just after the accepting edge.
    task automatic send_request(t_mode mode, t_coef x, t_coef y, t_coef z, bit known,
                                t_vec_result res);
        bit got;
        update_idle_profile();
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode  <= mode;
        req_ch.in_x  <= x;
        req_ch.in_y  <= y;
        req_ch.in_z  <= z;
        do begin
            @(negedge i_clk);
            got = req_ch.ready;
            @(posedge i_clk);
        end while (!got);
        pending_vectors.insert(pending_vectors.size(),
                               known ? res : transform_vector(mode, x, y, z));
        sent_count++;
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        while (pending_vectors.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_register(int idx, logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDX_W'(idx);
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx < NUM_REGS) begin
            mat_regs[idx] = data;
            rebuild_normal_matrix();
        end
    endtask

    function automatic t_coef pick_entry(t_mat_style style);
        case (style)
            MAT_ZERO:     return 0;
            MAT_ALL_MAX:  return 32'sh7fff_ffff;
            MAT_ALL_MIN:  return 32'sh8000_0000;
            MAT_RAW_BITS: return t_coef'($urandom);
            default:      return t_coef'(int'($urandom_range(8 << FRAC_BITS))
                                         - (4 << FRAC_BITS));
        endcase
    endfunction

    task automatic program_matrix(t_mat_style style);
        logic [63:0] data;
        for (int r = 0; r < NUM_REGS; r++) begin
            data = {pick_entry(style), pick_entry(style)};
            // Translations get a wider spread than the linear part.
            if (style == MAT_SMALL && r % 2 == 1)
                data[63:32] = t_coef'(int'($urandom_range(32'h0200_0000)) - 32'h0100_0000);
            write_register(r, data);
        end
        if (style == MAT_SMALL_BAD_IDX) begin
            write_register(NUM_REGS, 64'hffff_ffff_ffff_ffff);
            write_register((1 << CFG_IDX_W) - 1, 64'h0);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_coef random_component();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5) return t_coef'(int'($urandom_range(32'h0020_0000)) - 32'h0010_0000);
        if (sel < 8) return t_coef'($urandom);
        case ($urandom_range(3))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    t_directed_row directed [] = '{
        '{MODE_VERTEX, 0, 0, 0, 1, '{0, 0, 0, 0}},
        '{MODE_VERTEX, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1,
          '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0}},
        '{MODE_VERTEX, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1,
          '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0}},
        '{MODE_VERTEX, 1, -1, 32'sh1234_5678, 1, '{1, -1, 32'sh1234_5678, 0}},
        '{MODE_VERTEX, 32'sh7fff_ffff, 32'sh8000_0000, 65536, 1,
          '{32'sh7fff_ffff, 32'sh8000_0000, 65536, 0}},
        '{MODE_NORMAL, 65536, 0, 0, 1, '{65536, 0, 0, 0}},
        '{MODE_NORMAL, 0, 65536, 0, 1, '{0, 65536, 0, 0}},
        '{MODE_NORMAL, 0, 0, -65536, 1, '{0, 0, -65536, 0}},
        '{MODE_NORMAL, 1, 0, 0, 1, '{65536, 0, 0, 0}},
        '{MODE_NORMAL, 32'sh8000_0000, 0, 0, 1, '{-65536, 0, 0, 0}},
        '{MODE_NORMAL, 0, 0, 0, 1, '{0, 0, 0, 1}},
        '{MODE_NORMAL, 32'sh7fff_ffff, 32'sh8000_0000, 1, 0, '{0, 0, 0, 0}},
        '{MODE_NORMAL, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, '{0, 0, 0, 0}},
        '{MODE_NORMAL, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, '{0, 0, 0, 0}},
        '{MODE_NORMAL, 3, -4, 0, 0, '{0, 0, 0, 0}},
        '{MODE_NORMAL, -1, -1, -1, 0, '{0, 0, 0, 0}},
        '{MODE_VERTEX, -1, -1, -1, 1, '{-1, -1, -1, 0}}
    };

    initial begin
        t_mat_style style;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        req_ch.valid  <= 1'b0;
        req_ch.mode   <= 1'b0;
        req_ch.in_x   <= '0;
        req_ch.in_y   <= '0;
        req_ch.in_z   <= '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int r = 0; r < NUM_REGS; r++) mat_regs[r] = '0;
        mat_regs[0] = 64'd1 << FRAC_BITS;
        mat_regs[2] = 64'd1 << (32 + FRAC_BITS);
        mat_regs[5] = 64'd1 << FRAC_BITS;
        mat_regs[7] = 64'd1 << (32 + FRAC_BITS);
        rebuild_normal_matrix();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            send_request(directed[i].mode, directed[i].x, directed[i].y, directed[i].z,
                         directed[i].known, directed[i].res);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_for_results();
            case (ph)
                1:       style = MAT_ZERO;
                3:       style = MAT_ALL_MAX;
                5:       style = MAT_ALL_MIN;
                6:       style = MAT_RAW_BITS;
                8:       style = MAT_SMALL_BAD_IDX;
                default: style = MAT_SMALL;
            endcase
            program_matrix(style);
            for (int n = 0; n < PHASE_LEN; n++) begin
                // Let the pipeline run completely dry once mid-phase.
                if (ph == 2 && n == PHASE_LEN / 2) begin
                    req_ch.valid <= 1'b0;
                    while (pending_vectors.size() != 0) @(posedge i_clk);
                end
                send_request(t_mode'($urandom_range(1)), random_component(),
                             random_component(), random_component(), 0, '0);
            end
        end

        wait_for_results();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/vnt_pkg.sv
hw/rtl/vnt_req_if.sv
hw/rtl/vnt_rsp_if.sv
hw/rtl/vnt_derive.sv
hw/rtl/vnt_datapath.sv
hw/rtl/vertex_normal_transform.sv
tb/tb_vertex_normal_transform.sv
